>>> rtl/gnta_pkg.sv
// ----------------------------------------------------------------------------
// gnta_pkg
// Shared constants and codes for the greedy nearest track assignment block.
// ----------------------------------------------------------------------------
`default_nettype none

package gnta_pkg;

  // Table size and stored coordinate precision
  localparam int MAX_AGENTS = 16;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;

  // Field widths of the transaction payloads
  localparam int FUNC_W  = 2;
  localparam int COORD_W = 16;
  localparam int HEAD_W  = 16;
  localparam int SEL_W   = 4;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 5;

  // Mask applied to incoming coordinates before they are used or stored
  localparam logic [COORD_W-1:0] COORD_MASK =
    COORD_W'((64'd1 << COORD_BITS) - 64'd1);

  // Item kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_FRAME  = 2'd0,
    FUNC_DETECT = 2'd1,
    FUNC_LOAD   = 2'd2,
    FUNC_READ   = 2'd3
  } gnta_func_e;

endpackage

`default_nettype wire

>>> rtl/gnta_in_if.sv
// ----------------------------------------------------------------------------
// gnta_in_if
// Input channel: one item kind plus detection / load / read arguments.
// ----------------------------------------------------------------------------
`default_nettype none

interface gnta_in_if
  import gnta_pkg::*;
();

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic [COORD_W-1:0]        det_x;
  logic [COORD_W-1:0]        det_y;
  logic signed [HEAD_W-1:0]  det_heading;
  logic                      has_heading;
  logic [SEL_W-1:0]          agent_sel;
  logic [TIME_W-1:0]         frame_time;

  modport source (
    output valid, func, det_x, det_y, det_heading, has_heading, agent_sel, frame_time,
    input  ready
  );

  modport sink (
    input  valid, func, det_x, det_y, det_heading, has_heading, agent_sel, frame_time,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/gnta_out_if.sv
// ----------------------------------------------------------------------------
// gnta_out_if
// Result channel: one agent record per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface gnta_out_if
  import gnta_pkg::*;
();

  logic                      valid;
  logic                      ready;
  logic                      matched;
  logic [SEL_W-1:0]          agent_index;
  logic [COORD_W-1:0]        pos_x;
  logic [COORD_W-1:0]        pos_y;
  logic signed [HEAD_W-1:0]  heading;
  logic                      pos_valid;
  logic                      heading_valid;
  logic [TIME_W-1:0]         agent_time;

  modport source (
    output valid, matched, agent_index, pos_x, pos_y, heading, pos_valid,
           heading_valid, agent_time,
    input  ready
  );

  modport sink (
    input  valid, matched, agent_index, pos_x, pos_y, heading, pos_valid,
           heading_valid, agent_time,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/gnta_ram.sv
// ----------------------------------------------------------------------------
// gnta_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gnta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/greedy_nearest_track_assign.sv
// ----------------------------------------------------------------------------
// greedy_nearest_track_assign
// Track table with greedy nearest-agent assignment of detections.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-----------------------------------------
//   in_i     | in  | valid/ready        | func, det_x/y, det_heading, has_heading,
//            |     |                    | agent_sel, frame_time
//   out_o    | out | valid/ready        | matched, agent_index, pos_x/y, heading,
//            |     |                    | pos_valid, heading_valid, agent_time
//   cfg      | in  | cfg_we_i           | cfg_wdata_i = agent_count
//
// One item is in flight at a time. Frame start: accept moves the block straight
// to the response state. Load / read: one RAM read, then a write-back for a
// load. Detection walks the agent RAM through one read port into a single
// distance pipeline (abs diff, square, sum and compare). The input is ready
// again the cycle after the result register loads. A new item is accepted
// while the previous result waits in the output register; a stalled output
// holds the next result in its final state. Reset is asynchronous; the table
// reads as zero until written.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_nearest_track_assign
  import gnta_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  gnta_in_if.sink               in_i,
  gnta_out_if.source            out_o
);

  typedef struct packed {
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       y;
    logic signed [HEAD_W-1:0] h;
    logic [TIME_W-1:0]        t;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam int SQ_W    = 2 * COORD_W;

  typedef struct packed {
    logic                     matched;
    logic [SEL_W-1:0]         idx;
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       y;
    logic signed [HEAD_W-1:0] h;
    logic                     pv;
    logic                     hv;
    logic [TIME_W-1:0]        t;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE,
    ST_FETCH,
    ST_RESP
  } state_e;

  state_e state_q;

  // Architectural state outside the RAM
  logic [CNT_W-1:0]      agent_count_q;
  logic [MAX_AGENTS-1:0] mask_q;
  logic [MAX_AGENTS-1:0] pos_valid_q;
  logic [MAX_AGENTS-1:0] head_valid_q;
  logic [MAX_AGENTS-1:0] written_q;
  logic [TIME_W-1:0]     cur_time_q;

  // Latched item
  gnta_func_e               func_q;
  logic [COORD_W-1:0]       dx_q;
  logic [COORD_W-1:0]       dy_q;
  logic signed [HEAD_W-1:0] dh_q;
  logic                     hash_q;
  logic [IDX_W-1:0]         raddr_q;

  // Scan pipeline
  logic [IDX_W-1:0]         rd_idx_q;
  logic                     issue_q;
  logic                     o0_q;
  logic [IDX_W-1:0]         idx0_q;
  logic                     o1_q, e1_q;
  logic [IDX_W-1:0]         idx1_q;
  logic [COORD_W-1:0]       ax1_q, ay1_q;
  logic signed [HEAD_W-1:0] h1_q;
  logic                     o2_q, e2_q;
  logic [IDX_W-1:0]         idx2_q;
  logic [SQ_W-1:0]          sx2_q, sy2_q;
  logic signed [HEAD_W-1:0] h2_q;
  logic                     found_q;
  logic [SQ_W:0]            best_sum_q;
  logic [IDX_W-1:0]         best_idx_q;
  logic signed [HEAD_W-1:0] best_h_q;

  // Result registers
  res_t pend_q;
  res_t out_q;
  logic out_valid_q;

  // RAM port signals
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic                  accept;
  logic                  sel_ok;
  gnta_func_e            in_func;
  logic [COORD_W-1:0]    in_x, in_y;
  entry_t                rd_entry;
  logic [COORD_W-1:0]    ax_c, ay_c;
  logic [SQ_W-1:0]       sx_c, sy_c;
  logic [SQ_W:0]         sum_c;
  logic                  better_c;
  logic                  last_c;
  logic                  out_free;
  logic [MAX_AGENTS-1:0] refill_c;
  entry_t                wr_entry;
  res_t                  fetch_res;
  res_t                  done_res;

  gnta_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_AGENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake and input decode
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && (state_q == ST_IDLE);
  assign in_func    = gnta_func_e'(in_i.func);
  assign sel_ok     = (int'(in_i.agent_sel) < MAX_AGENTS);
  assign in_x       = in_i.det_x & COORD_MASK;
  assign in_y       = in_i.det_y & COORD_MASK;
  assign out_free   = !out_valid_q || out_o.ready;

  // Entries never written read as zero
  assign rd_entry = written_q[raddr_q] ? entry_t'(ram_rdata) : '0;

  // RAM read: agent fetch on accept, or the scan walk
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = rd_idx_q;
    if (state_q == ST_IDLE) begin
      ram_raddr = IDX_W'(in_i.agent_sel);
      ram_re    = accept && sel_ok && (in_func == FUNC_LOAD || in_func == FUNC_READ);
    end else if (state_q == ST_SCAN) begin
      ram_re = issue_q;
    end
  end

  // Distance pipeline datapath
  assign ax_c     = (dx_q > rd_entry.x) ? dx_q - rd_entry.x : rd_entry.x - dx_q;
  assign ay_c     = (dy_q > rd_entry.y) ? dy_q - rd_entry.y : rd_entry.y - dy_q;
  assign sx_c     = ax1_q * ax1_q;
  assign sy_c     = ay1_q * ay1_q;
  assign sum_c    = {1'b0, sx2_q} + {1'b0, sy2_q};
  assign better_c = e2_q && (!found_q || (sum_c < best_sum_q));
  assign last_c   = o2_q && (idx2_q == IDX_W'(MAX_AGENTS - 1));

  // Mask refill for frame start, count clamped to the table size
  always_comb begin
    for (int i = 0; i < MAX_AGENTS; i++) begin
      refill_c[i] = (i < int'(agent_count_q));
    end
  end

  // Write-back and result assembly for detection and load/read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = raddr_q;
    wr_entry  = rd_entry;

    done_res         = '0;
    done_res.matched = 1'b1;
    done_res.idx     = SEL_W'(best_idx_q);
    done_res.x       = dx_q;
    done_res.y       = dy_q;
    done_res.h       = hash_q ? dh_q : best_h_q;
    done_res.pv      = 1'b1;
    done_res.hv      = hash_q;
    done_res.t       = cur_time_q;

    fetch_res         = '0;
    fetch_res.idx     = SEL_W'(raddr_q);
    fetch_res.x       = (func_q == FUNC_LOAD) ? dx_q : rd_entry.x;
    fetch_res.y       = (func_q == FUNC_LOAD) ? dy_q : rd_entry.y;
    fetch_res.h       = rd_entry.h;
    fetch_res.pv      = pos_valid_q[raddr_q];
    fetch_res.hv      = head_valid_q[raddr_q];
    fetch_res.t       = rd_entry.t;

    if (state_q == ST_DONE) begin
      ram_we     = found_q;
      ram_waddr  = best_idx_q;
      wr_entry.x = dx_q;
      wr_entry.y = dy_q;
      wr_entry.h = done_res.h;
      wr_entry.t = cur_time_q;
    end else if (state_q == ST_FETCH) begin
      ram_we     = (func_q == FUNC_LOAD);
      wr_entry.x = dx_q;
      wr_entry.y = dy_q;
    end
  end

  assign ram_wdata = wr_entry;

  // Control state, table marks, scan pipeline and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      agent_count_q <= '0;
      mask_q        <= '0;
      pos_valid_q   <= '0;
      head_valid_q  <= '0;
      written_q     <= '0;
      cur_time_q    <= '0;
      issue_q       <= 1'b0;
      o0_q          <= 1'b0;
      o1_q          <= 1'b0;
      e1_q          <= 1'b0;
      o2_q          <= 1'b0;
      e2_q          <= 1'b0;
      found_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      // Configuration write
      if (cfg_we_i) begin
        agent_count_q <= (int'(cfg_wdata_i) > MAX_AGENTS) ? CNT_W'(MAX_AGENTS)
                                                          : cfg_wdata_i;
      end

      // Output register loads from the response state, drains on its transaction
      if (state_q == ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            func_q  <= in_func;
            dx_q    <= in_x;
            dy_q    <= in_y;
            dh_q    <= in_i.det_heading;
            hash_q  <= in_i.has_heading;
            raddr_q <= IDX_W'(in_i.agent_sel);
            pend_q  <= '0;
            unique case (in_func)
              FUNC_FRAME: begin
                pos_valid_q  <= '0;
                head_valid_q <= '0;
                mask_q       <= refill_c;
                cur_time_q   <= in_i.frame_time;
                state_q      <= ST_RESP;
              end
              FUNC_DETECT: begin
                rd_idx_q <= '0;
                issue_q  <= 1'b1;
                o0_q     <= 1'b0;
                o1_q     <= 1'b0;
                e1_q     <= 1'b0;
                o2_q     <= 1'b0;
                e2_q     <= 1'b0;
                found_q  <= 1'b0;
                state_q  <= ST_SCAN;
              end
              FUNC_LOAD, FUNC_READ: begin
                if (sel_ok) begin
                  state_q <= ST_FETCH;
                end else begin
                  // Out-of-range agent: index echoed, everything else zero
                  pend_q.idx <= in_i.agent_sel;
                  state_q    <= ST_RESP;
                end
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end

        ST_SCAN: begin
          // Read issue
          if (issue_q) begin
            raddr_q  <= rd_idx_q;
            rd_idx_q <= rd_idx_q + 1'b1;
            if (rd_idx_q == IDX_W'(MAX_AGENTS - 1)) begin
              issue_q <= 1'b0;
            end
          end
          o0_q   <= issue_q;
          idx0_q <= rd_idx_q;
          // Absolute differences
          o1_q   <= o0_q;
          e1_q   <= o0_q && mask_q[idx0_q];
          idx1_q <= idx0_q;
          ax1_q  <= ax_c;
          ay1_q  <= ay_c;
          h1_q   <= rd_entry.h;
          // Squares
          o2_q   <= o1_q;
          e2_q   <= e1_q;
          idx2_q <= idx1_q;
          sx2_q  <= sx_c;
          sy2_q  <= sy_c;
          h2_q   <= h1_q;
          // Sum and running minimum, lowest index kept on ties
          if (better_c) begin
            found_q    <= 1'b1;
            best_sum_q <= sum_c;
            best_idx_q <= idx2_q;
            best_h_q   <= h2_q;
          end
          // Earlier stages are already empty when the last agent arrives
          if (last_c) begin
            state_q <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (found_q) begin
            written_q[best_idx_q]    <= 1'b1;
            pos_valid_q[best_idx_q]  <= 1'b1;
            head_valid_q[best_idx_q] <= hash_q;
            mask_q[best_idx_q]       <= 1'b0;
            pend_q                   <= done_res;
          end
          state_q <= ST_RESP;
        end

        ST_FETCH: begin
          if (func_q == FUNC_LOAD) begin
            written_q[raddr_q] <= 1'b1;
          end
          pend_q  <= fetch_res;
          state_q <= ST_RESP;
        end

        ST_RESP: begin
          if (out_free) begin
            out_q   <= pend_q;
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result channel
  assign out_o.valid         = out_valid_q;
  assign out_o.matched       = out_q.matched;
  assign out_o.agent_index   = out_q.idx;
  assign out_o.pos_x         = out_q.x;
  assign out_o.pos_y         = out_q.y;
  assign out_o.heading       = out_q.h;
  assign out_o.pos_valid     = out_q.pv;
  assign out_o.heading_valid = out_q.hv;
  assign out_o.agent_time    = out_q.t;

endmodule

`default_nettype wire

>>> tb/greedy_nearest_track_assign_tb.sv
// ----------------------------------------------------------------------------
// greedy_nearest_track_assign_tb
// Self-checking bench for the greedy nearest track assignment block. A shadow
// track table predicts every result record. Directed tests cover the empty
// table, coordinate extremes, ties, heading handling, the agent count clamp
// and an exhausted mask. Random frames of near and far detections follow,
// with mixed loads, reads and noise, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greedy_nearest_track_assign_tb;
  import gnta_pkg::*;

  localparam int RAND_ITEMS  = 600;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 32;

  // One input transaction
  typedef struct {
    gnta_func_e               func;
    logic [COORD_W-1:0]       det_x;
    logic [COORD_W-1:0]       det_y;
    logic [HEAD_W-1:0]        det_heading;
    logic                     has_heading;
    logic [SEL_W-1:0]         agent_sel;
    logic [TIME_W-1:0]        frame_time;
  } track_cmd_t;

  // One result transaction
  typedef struct packed {
    logic                     matched;
    logic [SEL_W-1:0]         agent_index;
    logic [COORD_W-1:0]       pos_x;
    logic [COORD_W-1:0]       pos_y;
    logic [HEAD_W-1:0]        heading;
    logic                     pos_valid;
    logic                     heading_valid;
    logic [TIME_W-1:0]        agent_time;
  } track_rec_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  gnta_in_if  in_if ();
  gnta_out_if out_if ();

  greedy_nearest_track_assign i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Shadow track table
  logic [COORD_W-1:0]    trk_x        [MAX_AGENTS];
  logic [COORD_W-1:0]    trk_y        [MAX_AGENTS];
  logic [HEAD_W-1:0]     trk_head     [MAX_AGENTS];
  logic                  trk_pos_ok   [MAX_AGENTS];
  logic                  trk_head_ok  [MAX_AGENTS];
  logic [TIME_W-1:0]     trk_time     [MAX_AGENTS];
  logic [MAX_AGENTS-1:0] free_mask;
  logic [TIME_W-1:0]     frame_now;
  logic [CNT_W-1:0]      agent_count;

  track_rec_t  exp_rec_q [$];
  int unsigned items_sent;
  int unsigned err_cnt;
  int unsigned quiet_cycles;
  bit          idle_en;
  bit          stall_en;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Record of one agent as the block reports it
  function automatic track_rec_t agent_rec(int idx, logic matched);
    track_rec_t rec;
    rec.matched       = matched;
    rec.agent_index   = SEL_W'(idx);
    rec.pos_x         = trk_x[idx];
    rec.pos_y         = trk_y[idx];
    rec.heading       = trk_head[idx];
    rec.pos_valid     = trk_pos_ok[idx];
    rec.heading_valid = trk_head_ok[idx];
    rec.agent_time    = trk_time[idx];
    return rec;
  endfunction

  // Apply one transaction to the shadow table and return the expected record
  function automatic track_rec_t step_tracks(track_cmd_t cmd);
    track_rec_t         rec;
    int                 n;
    int                 best;
    logic [32:0]        best_d;
    logic [32:0]        d;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    rec = '0;
    cx  = cmd.det_x & COORD_MASK;
    cy  = cmd.det_y & COORD_MASK;
    case (cmd.func)
      FUNC_FRAME: begin
        n = (int'(agent_count) > MAX_AGENTS) ? MAX_AGENTS : int'(agent_count);
        for (int i = 0; i < MAX_AGENTS; i++) begin
          trk_pos_ok[i]  = 1'b0;
          trk_head_ok[i] = 1'b0;
          free_mask[i]   = (i < n);
        end
        frame_now = cmd.frame_time;
      end
      FUNC_DETECT: begin
        best   = -1;
        best_d = '0;
        // Squared distance with carry; strict compare keeps the lowest index
        for (int i = 0; i < MAX_AGENTS; i++) begin
          if (free_mask[i]) begin
            ax = (cx > trk_x[i]) ? cx - trk_x[i] : trk_x[i] - cx;
            ay = (cy > trk_y[i]) ? cy - trk_y[i] : trk_y[i] - cy;
            d  = (33'(ax) * 33'(ax)) + (33'(ay) * 33'(ay));
            if (best < 0 || d < best_d) begin
              best   = i;
              best_d = d;
            end
          end
        end
        if (best >= 0) begin
          trk_x[best]      = cx;
          trk_y[best]      = cy;
          trk_pos_ok[best] = 1'b1;
          if (cmd.has_heading) begin
            trk_head[best]    = cmd.det_heading;
            trk_head_ok[best] = 1'b1;
          end else begin
            trk_head_ok[best] = 1'b0;
          end
          trk_time[best]  = frame_now;
          free_mask[best] = 1'b0;
          rec = agent_rec(best, 1'b1);
        end
      end
      default: begin
        if (int'(cmd.agent_sel) >= MAX_AGENTS) begin
          rec.agent_index = cmd.agent_sel;
        end else begin
          if (cmd.func == FUNC_LOAD) begin
            trk_x[cmd.agent_sel] = cx;
            trk_y[cmd.agent_sel] = cy;
          end
          rec = agent_rec(int'(cmd.agent_sel), 1'b0);
        end
      end
    endcase
    return rec;
  endfunction

  // Transaction with every field random
  function automatic track_cmd_t rand_cmd(gnta_func_e func);
    track_cmd_t cmd;
    cmd.func        = func;
    cmd.det_x       = COORD_W'($urandom_range(65535));
    cmd.det_y       = COORD_W'($urandom_range(65535));
    cmd.det_heading = HEAD_W'($urandom_range(65535));
    cmd.has_heading = 1'($urandom_range(1));
    cmd.agent_sel   = SEL_W'($urandom_range(15));
    cmd.frame_time  = $urandom;
    return cmd;
  endfunction

  // Send one transaction, with an optional random gap before it
  task automatic send_item(input track_cmd_t cmd);
    int unsigned gap;
    gap = 0;
    @(negedge clk_i);
    if (idle_en) begin
      while ($urandom_range(99) < 14) gap++;
    end
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.func        <= cmd.func;
    in_if.det_x       <= cmd.det_x;
    in_if.det_y       <= cmd.det_y;
    in_if.det_heading <= cmd.det_heading;
    in_if.has_heading <= cmd.has_heading;
    in_if.agent_sel   <= cmd.agent_sel;
    in_if.frame_time  <= cmd.frame_time;
    in_if.valid       <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    exp_rec_q.push_back(step_tracks(cmd));
    items_sent++;
  endtask

  // Stop sending and wait for every expected record
  task automatic wait_tracks_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (exp_rec_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Agent count write, only while the block is idle
  task automatic set_agent_count(input logic [CNT_W-1:0] value);
    wait_tracks_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    agent_count  = value;
  endtask

  // Short helpers for directed transactions
  task automatic send_load(input int sel, input logic [15:0] x, input logic [15:0] y);
    track_cmd_t cmd;
    cmd           = rand_cmd(FUNC_LOAD);
    cmd.agent_sel = SEL_W'(sel);
    cmd.det_x     = x;
    cmd.det_y     = y;
    send_item(cmd);
  endtask

  task automatic send_detect(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] h, input logic hh);
    track_cmd_t cmd;
    cmd             = rand_cmd(FUNC_DETECT);
    cmd.det_x       = x;
    cmd.det_y       = y;
    cmd.det_heading = h;
    cmd.has_heading = hh;
    send_item(cmd);
  endtask

  task automatic send_read(input int sel);
    track_cmd_t cmd;
    cmd           = rand_cmd(FUNC_READ);
    cmd.agent_sel = SEL_W'(sel);
    send_item(cmd);
  endtask

  task automatic send_frame(input logic [31:0] t);
    track_cmd_t cmd;
    cmd            = rand_cmd(FUNC_FRAME);
    cmd.frame_time = t;
    send_item(cmd);
  endtask

  // Empty table: reads of zeroed agents, detection with no agent left
  task automatic test_empty_table();
    set_agent_count(CNT_W'(0));
    send_read(0);
    send_read(MAX_AGENTS - 1);
    send_frame(32'h0);
    send_detect(16'h1234, 16'h5678, 16'h0100, 1'b1);
  endtask

  // Corner coordinates, ties to lowest index, carry in the distance sum
  task automatic test_extreme_coords();
    set_agent_count(CNT_W'(MAX_AGENTS));
    send_load(0, 16'h0000, 16'h0000);
    send_load(1, 16'hFFFF, 16'hFFFF);
    send_load(2, 16'hFFFF, 16'h0000);
    send_load(3, 16'h0000, 16'hFFFF);
    send_frame(32'hFFFF_FFFF);
    send_detect(16'h0000, 16'h0000, 16'h8000, 1'b1);
    send_detect(16'h0000, 16'h0000, 16'h1111, 1'b0);
    send_detect(16'hFFFF, 16'hFFFF, 16'h7FFF, 1'b1);
    send_detect(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    send_detect(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
  endtask

  // Counts above the table size clamp to a full table
  task automatic test_count_clamp();
    set_agent_count(CNT_W'(31));
    send_frame(32'h0000_0001);
    send_detect(16'h8000, 16'h8000, 16'h7FFF, 1'b1);
    send_read(0);
  endtask

  // One agent: second detection finds the mask empty
  task automatic test_single_agent();
    set_agent_count(CNT_W'(1));
    send_frame(32'hA5A5_5A5A);
    send_detect(16'h0040, 16'h0080, 16'hC000, 1'b1);
    send_detect(16'h0041, 16'h0081, 16'h4000, 1'b1);
    send_read(0);
  endtask

  // Random frames of detections around known tracks, with loads, reads, noise
  task automatic test_random_frames();
    int unsigned start;
    int unsigned phase;
    int unsigned n;
    int unsigned ndet;
    int unsigned j;
    track_cmd_t  cmd;
    start = items_sent;
    phase = 0;
    while (items_sent - start < RAND_ITEMS) begin
      case (phase % 6)
        0:       set_agent_count(CNT_W'(MAX_AGENTS));
        1:       set_agent_count(CNT_W'(0));
        2:       set_agent_count(CNT_W'(1));
        3:       set_agent_count(CNT_W'(31));
        default: set_agent_count(CNT_W'($urandom_range(31)));
      endcase
      // One phase runs with no gaps and no stalls at all
      idle_en  = (phase != 3);
      stall_en = (phase != 3);
      n = (int'(agent_count) > MAX_AGENTS) ? MAX_AGENTS : int'(agent_count);
      for (int i = 0; i < MAX_AGENTS; i++) begin
        if ($urandom_range(1)) begin
          cmd           = rand_cmd(FUNC_LOAD);
          cmd.agent_sel = SEL_W'(i);
          send_item(cmd);
        end
      end
      repeat ($urandom_range(4, 8)) begin
        send_item(rand_cmd(FUNC_FRAME));
        ndet = $urandom_range(n + 2);
        repeat (ndet) begin
          j = $urandom_range(9);
          if (j == 0) begin
            send_item(rand_cmd(gnta_func_e'($urandom_range(3))));
          end else if (j == 1) begin
            send_item(rand_cmd($urandom_range(1) ? FUNC_LOAD : FUNC_READ));
          end else begin
            cmd = rand_cmd(FUNC_DETECT);
            j   = $urandom_range(MAX_AGENTS - 1);
            case ($urandom_range(3))
              0: ;
              1: begin
                cmd.det_x = trk_x[j];
                cmd.det_y = trk_y[j];
              end
              default: begin
                cmd.det_x = trk_x[j] + COORD_W'($urandom_range(64)) - COORD_W'(32);
                cmd.det_y = trk_y[j] + COORD_W'($urandom_range(64)) - COORD_W'(32);
              end
            endcase
            send_item(cmd);
          end
        end
      end
      phase++;
    end
    idle_en  = 1'b1;
    stall_en = 1'b1;
  endtask

  // Output ready with random stalls
  always @(negedge clk_i) begin
    out_if.ready <= !stall_en || ($urandom_range(99) >= 14);
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Compare each result transaction with the oldest expected record
  always @(posedge clk_i) begin
    track_rec_t rec;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (exp_rec_q.size() == 0) begin
        $error("result transaction with no expected record");
        err_cnt++;
      end else begin
        rec = exp_rec_q.pop_front();
        check_field("matched",       32'(rec.matched),       32'(out_if.matched));
        check_field("agent_index",   32'(rec.agent_index),   32'(out_if.agent_index));
        check_field("pos_x",         32'(rec.pos_x),         32'(out_if.pos_x));
        check_field("pos_y",         32'(rec.pos_y),         32'(out_if.pos_y));
        check_field("heading",       32'(rec.heading),       32'(unsigned'(out_if.heading)));
        check_field("pos_valid",     32'(rec.pos_valid),     32'(out_if.pos_valid));
        check_field("heading_valid", 32'(rec.heading_valid), 32'(out_if.heading_valid));
        check_field("agent_time",    rec.agent_time,         out_if.agent_time);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("greedy_nearest_track_assign: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Test sequence
  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.func        = FUNC_FRAME;
    in_if.det_x       = '0;
    in_if.det_y       = '0;
    in_if.det_heading = '0;
    in_if.has_heading = 1'b0;
    in_if.agent_sel   = '0;
    in_if.frame_time  = '0;
    out_if.ready      = 1'b0;
    items_sent        = 0;
    err_cnt           = 0;
    quiet_cycles      = 0;
    idle_en           = 1'b1;
    stall_en          = 1'b1;
    agent_count       = '0;
    free_mask         = '0;
    frame_now         = '0;
    for (int i = 0; i < MAX_AGENTS; i++) begin
      trk_x[i]       = '0;
      trk_y[i]       = '0;
      trk_head[i]    = '0;
      trk_pos_ok[i]  = 1'b0;
      trk_head_ok[i] = 1'b0;
      trk_time[i]    = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_extreme_coords();
    test_count_clamp();
    test_single_agent();
    test_random_frames();

    wait_tracks_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (exp_rec_q.size() != 0) begin
      $error("%0d expected records never arrived", exp_rec_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("greedy_nearest_track_assign: match");
    end else begin
      $display("greedy_nearest_track_assign: mismatch");
    end
    $finish;
  end

endmodule
